// ===== hdl/bps_pkg.sv =====
`default_nettype none
package bps_pkg;

  localparam int SLOT_COUNT = 8;
  localparam int SLOT_IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  localparam logic [15:0] HANDLE_LIMIT = 16'hFFFF;

  localparam logic [1:0] OP_TICK = 2'd0;
  localparam logic [1:0] OP_ADD  = 2'd1;
  localparam logic [1:0] OP_DEL  = 2'd2;
  localparam logic [1:0] OP_NOP  = 2'd3;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_ZERO_LEN  = 3'd1;
  localparam logic [2:0] ST_NO_SLOT   = 3'd2;
  localparam logic [2:0] ST_EXHAUSTED = 3'd3;
  localparam logic [2:0] ST_NOT_FOUND = 3'd4;

  // request as broadcast to every cell, held for the whole walk
  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] now;
    logic [31:0] start;
    logic [15:0] length;
    logic [15:0] gap;
    logic [7:0]  reps;
    logic [15:0] target;
  } req_t;

  // running record handed from cell to cell
  typedef struct packed {
    logic                  any;
    logic                  found;
    logic [SLOT_IDX_W-1:0] idx;
    logic [15:0]           top;
  } rec_t;

  // slot write after a successful add
  typedef struct packed {
    logic                  en;
    logic [SLOT_IDX_W-1:0] idx;
    logic [15:0]           handle;
  } commit_t;

endpackage
`default_nettype wire

// ===== hdl/beep_pattern_scheduler_top.sv =====
`default_nettype none
// Beep pattern scheduler: a table of SLOT_COUNT pattern slots driving one
// buzzer line.
// Input channel (in_valid / in_stall): one request per transfer, operation
// tick, add or delete, with its fields. Output channel (out_valid /
// out_stall): exactly one result per request: line level, new handle, status.
// Config channel (cfg_valid / cfg_ready): writes sound_enabled; ready is
// always high. Write it only while no request is in flight.
// Each request walks a chain of slot cells, one cell per cycle. After the
// last cell the controller registers the result (state S_DONE) and then
// raises out_valid; only then does it take the next request, so requests
// never overlap in the chain.
// A stalled result stays on the output ports; a request that finishes while
// the previous result still waits holds until it is taken, and no new
// request is taken meanwhile.
// Reset clears all slots, the last time and the line level, and sets
// sound_enabled to 1.
module beep_pattern_scheduler_top
  import bps_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  operation,
  input  wire logic [31:0] now_ms,
  input  wire logic [15:0] start_delay,
  input  wire logic [15:0] beep_length,
  input  wire logic [15:0] repeat_gap,
  input  wire logic [7:0]  beep_count,
  input  wire logic [15:0] target_handle,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             buzzer_on,
  output logic [15:0]      new_handle,
  output logic [2:0]       status,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        sound_enabled
);

  logic    launch;
  req_t    req;
  commit_t commit;
  logic    token [SLOT_COUNT+1];
  rec_t    rec   [SLOT_COUNT+1];

  assign token[0] = launch;
  assign rec[0]   = '0;

  for (genvar i = 0; i < SLOT_COUNT; i++) begin : g_cell
    bps_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .slot_index (SLOT_IDX_W'(i)),
      .req        (req),
      .commit     (commit),
      .token_in   (token[i]),
      .rec_in     (rec[i]),
      .token_out  (token[i+1]),
      .rec_out    (rec[i+1])
    );
  end

  bps_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .operation     (operation),
    .now_ms        (now_ms),
    .start_delay   (start_delay),
    .beep_length   (beep_length),
    .repeat_gap    (repeat_gap),
    .beep_count    (beep_count),
    .target_handle (target_handle),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .buzzer_on     (buzzer_on),
    .new_handle    (new_handle),
    .status        (status),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .sound_enabled (sound_enabled),
    .launch        (launch),
    .req           (req),
    .commit        (commit),
    .done_token    (token[SLOT_COUNT]),
    .done_rec      (rec[SLOT_COUNT])
  );

endmodule
`default_nettype wire

// ===== hdl/bps_cell.sv =====
`default_nettype none
module bps_cell
  import bps_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic [SLOT_IDX_W-1:0] slot_index,
  input  wire req_t                  req,
  input  wire commit_t               commit,
  input  wire logic                  token_in,
  input  wire rec_t                  rec_in,
  output logic                       token_out,
  output rec_t                       rec_out
);

  logic [15:0] handle;
  logic [31:0] start;
  logic [15:0] length;
  logic [15:0] gap;
  logic [7:0]  reps;
  logic        active;

  logic [31:0] end_time;
  logic        hit;
  logic        passed;
  logic        is_free;
  logic        match;
  rec_t        rec_next;

  always_comb begin
    end_time = start + {16'd0, length};
    hit      = (req.now >= start) && (req.now < end_time) && active;
    passed   = (req.now >= end_time);
    is_free  = (handle == 16'd0) || !active;
    match    = (handle == req.target);
    rec_next = rec_in;
    if (token_in) begin
      case (req.op)
        OP_TICK: rec_next.any = rec_in.any | hit;
        OP_ADD: begin
          if (is_free && !rec_in.found) begin
            rec_next.found = 1'b1;
            rec_next.idx   = slot_index;
          end
          if (handle > rec_in.top) rec_next.top = handle;
        end
        OP_DEL: begin
          if (match && !rec_in.found) rec_next.found = 1'b1;
        end
        default: rec_next = rec_in;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      handle    <= '0;
      start     <= '0;
      length    <= '0;
      gap       <= '0;
      reps      <= '0;
      active    <= 1'b0;
      token_out <= 1'b0;
    end else begin
      token_out <= token_in;
      if (token_in && req.op == OP_TICK && passed) begin
        // advance to the next beep or retire
        if (reps != 8'd0) begin
          start <= end_time + {16'd0, gap};
          reps  <= reps - 8'd1;
        end else begin
          active <= 1'b0;
        end
      end
      if (token_in && req.op == OP_DEL && match && !rec_in.found) begin
        handle <= '0;
        active <= 1'b0;
      end
      if (commit.en && commit.idx == slot_index) begin
        handle <= commit.handle;
        start  <= req.start;
        length <= req.length;
        gap    <= req.gap;
        reps   <= req.reps;
        active <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rec_out <= rec_next;
  end

endmodule
`default_nettype wire

// ===== hdl/bps_ctrl.sv =====
`default_nettype none
module bps_ctrl
  import bps_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  operation,
  input  wire logic [31:0] now_ms,
  input  wire logic [15:0] start_delay,
  input  wire logic [15:0] beep_length,
  input  wire logic [15:0] repeat_gap,
  input  wire logic [7:0]  beep_count,
  input  wire logic [15:0] target_handle,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             buzzer_on,
  output logic [15:0]      new_handle,
  output logic [2:0]       status,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        sound_enabled,
  output logic             launch,
  output req_t             req,
  output commit_t          commit,
  input  wire logic        done_token,
  input  wire rec_t        done_rec
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_WALK = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0]  state;
  logic [31:0] last_time;
  logic        line_level;
  logic        sound_on;
  logic        pend_line;
  logic [15:0] pend_handle;
  logic [2:0]  pend_status;

  logic        accept;
  logic        deliver;
  logic        res_line;
  logic [15:0] res_handle;
  logic [2:0]  res_status;
  logic        res_commit;

  assign in_stall  = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = in_valid && !in_stall;
  assign deliver   = (state == S_DONE) && (!out_valid || !out_stall);

  always_comb begin
    res_line   = line_level;
    res_handle = '0;
    res_status = ST_OK;
    res_commit = 1'b0;
    case (req.op)
      OP_TICK: res_line = sound_on & done_rec.any;
      OP_ADD: begin
        if (req.length == 16'd0) begin
          res_status = ST_ZERO_LEN;
        end else if (!done_rec.found) begin
          res_status = ST_NO_SLOT;
        end else if (done_rec.top >= HANDLE_LIMIT - 16'd1) begin
          res_status = ST_EXHAUSTED;
        end else begin
          res_handle = done_rec.top + 16'd1;
          res_commit = 1'b1;
        end
      end
      OP_DEL: begin
        if (!done_rec.found) res_status = ST_NOT_FOUND;
      end
      default: res_line = line_level;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      last_time  <= '0;
      line_level <= 1'b0;
      sound_on   <= 1'b1;
      launch     <= 1'b0;
      commit.en  <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      launch    <= 1'b0;
      commit.en <= 1'b0;
      if (cfg_valid && cfg_ready) sound_on <= sound_enabled;
      if (out_valid && !out_stall) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (operation == OP_TICK) last_time <= now_ms;
            launch <= 1'b1;
            state  <= S_WALK;
          end
        end
        S_WALK: begin
          if (done_token) begin
            line_level    <= res_line;
            commit.en     <= res_commit;
            commit.idx    <= done_rec.idx;
            commit.handle <= res_handle;
            state         <= S_DONE;
          end
        end
        S_DONE: begin
          if (deliver) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      // a tick at the last time changes nothing: run it as a no-op
      if (operation == OP_TICK && now_ms == last_time) req.op <= OP_NOP;
      else req.op <= operation;
      req.now    <= now_ms;
      req.start  <= last_time + {16'd0, start_delay};
      req.length <= beep_length;
      req.gap    <= repeat_gap;
      req.reps   <= (beep_count != 8'd0) ? beep_count - 8'd1 : 8'd0;
      req.target <= target_handle;
    end
    if (state == S_WALK && done_token) begin
      pend_line   <= res_line;
      pend_handle <= res_handle;
      pend_status <= res_status;
    end
    if (deliver) begin
      buzzer_on  <= pend_line;
      new_handle <= pend_handle;
      status     <= pend_status;
    end
  end

endmodule
`default_nettype wire

// ===== tb/sv/beep_pattern_scheduler_checker.sv =====
`timescale 1ns / 1ps
module beep_pattern_scheduler_checker
  import bps_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  input  wire logic        in_stall,
  input  wire logic [1:0]  operation,
  input  wire logic [31:0] now_ms,
  input  wire logic [15:0] start_delay,
  input  wire logic [15:0] beep_length,
  input  wire logic [15:0] repeat_gap,
  input  wire logic [7:0]  beep_count,
  input  wire logic [15:0] target_handle,
  input  wire logic        out_valid,
  input  wire logic        out_stall,
  input  wire logic        buzzer_on,
  input  wire logic [15:0] new_handle,
  input  wire logic [2:0]  status,
  input  wire logic        cfg_valid,
  input  wire logic        cfg_ready,
  input  wire logic        sound_enabled,
  output int               mismatches,
  output int               pending,
  output int               checked
);

  localparam int MAX_REPORTS = 100;

  typedef struct packed {
    logic        line;
    logic [15:0] handle;
    logic [2:0]  code;
  } beep_result_t;

  logic [15:0] slot_id    [SLOT_COUNT];
  logic [31:0] slot_begin [SLOT_COUNT];
  logic [15:0] slot_len   [SLOT_COUNT];
  logic [15:0] slot_pause [SLOT_COUNT];
  logic [7:0]  slot_left  [SLOT_COUNT];
  logic        slot_live  [SLOT_COUNT];
  logic [31:0] seen_ms;
  logic        line_model;
  logic        sound_model;

  beep_result_t expected_results[$];
  beep_result_t want;
  beep_result_t got;

  initial begin
    mismatches = 0;
    pending = 0;
    checked = 0;
  end

  task automatic report_mismatch(input string msg);
    if (mismatches < MAX_REPORTS) begin
      $display("MISMATCH at %0t ns: %s", $time, msg);
    end
    mismatches++;
  endtask

  task automatic table_reset();
    for (int i = 0; i < SLOT_COUNT; i++) begin
      slot_id[i] = '0;
      slot_begin[i] = '0;
      slot_len[i] = '0;
      slot_pause[i] = '0;
      slot_left[i] = '0;
      slot_live[i] = 1'b0;
    end
    seen_ms = '0;
    line_model = 1'b0;
    sound_model = 1'b1;
  endtask

  task automatic tick_table(input logic [31:0] now);
    logic        hit;
    logic [31:0] win_end;
    hit = 1'b0;
    // same time: hold everything, line included
    if (now != seen_ms) begin
      seen_ms = now;
      for (int i = 0; i < SLOT_COUNT; i++) begin
        win_end = slot_begin[i] + {16'd0, slot_len[i]};
        if (now >= slot_begin[i] && now < win_end && slot_live[i]) begin
          hit = 1'b1;
        end
        // window passed: advance to next beep, or retire (inactive slots too)
        if (now >= win_end) begin
          if (slot_left[i] != 0) begin
            slot_begin[i] = win_end + {16'd0, slot_pause[i]};
            slot_left[i] = slot_left[i] - 8'd1;
          end else begin
            slot_live[i] = 1'b0;
          end
        end
      end
      line_model = sound_model & hit;
    end
  endtask

  task automatic add_pattern(input logic [15:0] delay, input logic [15:0] len,
                             input logic [15:0] gap, input logic [7:0] cnt,
                             output logic [15:0] handle, output logic [2:0] code);
    int          free_slot;
    logic [16:0] next_id;
    handle = '0;
    code = ST_OK;
    free_slot = -1;
    next_id = '0;
    if (len == 0) begin
      code = ST_ZERO_LEN;
    end else begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
        if (free_slot < 0 && (slot_id[i] == 0 || !slot_live[i])) begin
          free_slot = i;
        end
        if ({1'b0, slot_id[i]} > next_id) begin
          next_id = {1'b0, slot_id[i]};
        end
      end
      next_id = next_id + 17'd1;
      if (free_slot < 0) begin
        code = ST_NO_SLOT;
      end else if (next_id >= {1'b0, HANDLE_LIMIT}) begin
        code = ST_EXHAUSTED;
      end else begin
        slot_id[free_slot] = next_id[15:0];
        slot_begin[free_slot] = seen_ms + {16'd0, delay};
        slot_len[free_slot] = len;
        slot_pause[free_slot] = gap;
        slot_left[free_slot] = (cnt != 0) ? cnt - 8'd1 : 8'd0;
        slot_live[free_slot] = 1'b1;
        handle = next_id[15:0];
      end
    end
  endtask

  task automatic drop_pattern(input logic [15:0] target, output logic [2:0] code);
    code = ST_NOT_FOUND;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      if (code == ST_NOT_FOUND && slot_id[i] == target) begin
        slot_id[i] = '0;
        slot_live[i] = 1'b0;
        code = ST_OK;
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      table_reset();
      expected_results.delete();
    end else begin
      if (out_valid && !out_stall) begin
        got = '{line: buzzer_on, handle: new_handle, code: status};
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("result with no request waiting (line %0b handle %0d status %0d)",
                                    got.line, got.handle, got.code));
        end else begin
          want = expected_results.pop_front();
          checked++;
          if (got.line !== want.line) begin
            report_mismatch($sformatf("buzzer_on %0b, expected %0b", got.line, want.line));
          end
          if (got.handle !== want.handle) begin
            report_mismatch($sformatf("new_handle %0d, expected %0d", got.handle, want.handle));
          end
          if (got.code !== want.code) begin
            report_mismatch($sformatf("status %0d, expected %0d", got.code, want.code));
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        sound_model = sound_enabled;
      end
      if (in_valid && !in_stall) begin
        want = '{line: 1'b0, handle: 16'd0, code: ST_OK};
        case (operation)
          OP_TICK: tick_table(now_ms);
          OP_ADD: begin
            add_pattern(start_delay, beep_length, repeat_gap, beep_count, want.handle, want.code);
          end
          OP_DEL: drop_pattern(target_handle, want.code);
          default: ;
        endcase
        want.line = line_model;
        expected_results.push_back(want);
      end
    end
    pending = expected_results.size();
  end

endmodule

// ===== tb/sv/beep_pattern_scheduler_top_tb.sv =====
`timescale 1ns / 1ps
module beep_pattern_scheduler_top_tb;
  import bps_pkg::*;

  localparam int CLIMB_ROUNDS   = 32;
  localparam int PHASES         = 4;
  localparam int PHASE_ITEMS    = 400;
  localparam int WATCHDOG_LIMIT = 4000;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  operation;
  logic [31:0] now_ms;
  logic [15:0] start_delay;
  logic [15:0] beep_length;
  logic [15:0] repeat_gap;
  logic [7:0]  beep_count;
  logic [15:0] target_handle;
  logic        out_valid;
  logic        out_stall;
  logic        buzzer_on;
  logic [15:0] new_handle;
  logic [2:0]  status;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        sound_enabled;

  int mismatches;
  int pending;
  int checked;

  bit          gaps_on;
  int          requests_sent;
  int          sound_writes;
  int          adds_sent;
  int          quiet_cycles;
  int          roll;
  logic [31:0] last_tick;
  logic [1:0]  f_op;
  logic [31:0] f_now;
  logic [15:0] f_delay;
  logic [15:0] f_len;
  logic [15:0] f_gap;
  logic [7:0]  f_cnt;
  logic [15:0] f_target;

  beep_pattern_scheduler_top DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .operation(operation),
    .now_ms(now_ms),
    .start_delay(start_delay),
    .beep_length(beep_length),
    .repeat_gap(repeat_gap),
    .beep_count(beep_count),
    .target_handle(target_handle),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .buzzer_on(buzzer_on),
    .new_handle(new_handle),
    .status(status),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .sound_enabled(sound_enabled)
  );

  beep_pattern_scheduler_checker pattern_check (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .operation(operation),
    .now_ms(now_ms),
    .start_delay(start_delay),
    .beep_length(beep_length),
    .repeat_gap(repeat_gap),
    .beep_count(beep_count),
    .target_handle(target_handle),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .buzzer_on(buzzer_on),
    .new_handle(new_handle),
    .status(status),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .sound_enabled(sound_enabled),
    .mismatches(mismatches),
    .pending(pending),
    .checked(checked)
  );

  always #10 clk = ~clk;

  always @(negedge clk) begin
    out_stall <= gaps_on && ($urandom_range(0, 99) < 35);
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("Watchdog: no transfer for %0d cycles, %0d results outstanding",
               WATCHDOG_LIMIT, pending);
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_request(input logic [1:0] op, input logic [31:0] now,
                              input logic [15:0] delay, input logic [15:0] len,
                              input logic [15:0] gap, input logic [7:0] cnt,
                              input logic [15:0] target);
    @(negedge clk);
    while (gaps_on && $urandom_range(0, 99) < 35) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    operation <= op;
    now_ms <= now;
    start_delay <= delay;
    beep_length <= len;
    repeat_gap <= gap;
    beep_count <= cnt;
    target_handle <= target;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    requests_sent++;
  endtask

  task automatic send_tick(input logic [31:0] now);
    last_tick = now;
    send_request(OP_TICK, now, 16'($urandom), 16'($urandom), 16'($urandom), 8'($urandom),
                 16'($urandom));
  endtask

  // change the register only with nothing in flight
  task automatic write_sound(input logic value);
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    cfg_valid <= 1'b1;
    sound_enabled <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    sound_writes++;
  endtask

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    in_valid = 1'b0;
    operation = OP_TICK;
    now_ms = '0;
    start_delay = '0;
    beep_length = '0;
    repeat_gap = '0;
    beep_count = '0;
    target_handle = '0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    sound_enabled = 1'b1;
    gaps_on = 1'b0;
    requests_sent = 0;
    sound_writes = 0;
    adds_sent = 8;
    quiet_cycles = 0;
    last_tick = '0;
    repeat (5) @(negedge clk);
    rst <= 1'b0;

    // Cycle the table: fill all slots with one-shot beeps, retire them with
    // one tick, repeat. Handles keep growing since retired slots keep theirs.
    write_sound(1'b1);
    for (int r = 0; r < CLIMB_ROUNDS; r++) begin
      for (int s = 0; s < SLOT_COUNT; s++) begin
        send_request(OP_ADD, $urandom, 16'd0, 16'd1, 16'($urandom), 8'($urandom_range(0, 1)),
                     16'($urandom));
      end
      send_tick(last_tick + 32'd100);
    end
    // drop every handle left in the table, with misses on both sides
    for (int h = CLIMB_ROUNDS * SLOT_COUNT - 8; h <= CLIMB_ROUNDS * SLOT_COUNT + 8; h++) begin
      send_request(OP_DEL, $urandom, 16'($urandom), 16'($urandom), 16'($urandom), 8'($urandom),
                   16'(h));
    end

    gaps_on = 1'b1;
    send_tick(last_tick);
    send_request(OP_ADD, $urandom, 16'd3, 16'd0, 16'd4, 8'd2, 16'($urandom));
    send_request(OP_ADD, $urandom, 16'd0, 16'hFFFF, 16'hFFFF, 8'hFF, 16'($urandom));
    send_request(OP_ADD, $urandom, 16'd5, 16'd3, 16'd2, 8'd3, 16'($urandom));
    send_request(OP_ADD, $urandom, 16'd1, 16'd1, 16'd0, 8'd1, 16'($urandom));
    send_request(OP_ADD, $urandom, 16'hFFFF, 16'd1, 16'd0, 8'd0, 16'($urandom));
    send_tick(last_tick + 32'd1);
    send_tick(last_tick + 32'd5);
    send_request(OP_NOP, $urandom, 16'($urandom), 16'($urandom), 16'($urandom), 8'($urandom),
                 16'($urandom));
    send_request(OP_DEL, $urandom, 16'($urandom), 16'($urandom), 16'($urandom), 8'($urandom),
                 16'hFFFF);
    send_request(OP_DEL, $urandom, 16'($urandom), 16'($urandom), 16'($urandom), 8'($urandom),
                 16'd0);
    for (int s = 0; s < SLOT_COUNT; s++) begin
      send_request(OP_ADD, $urandom, 16'd0, 16'd1000, 16'd10, 8'd4, 16'($urandom));
    end
    send_request(OP_ADD, $urandom, 16'd0, 16'd0, 16'd0, 8'd0, 16'($urandom));
    write_sound(1'b0);
    send_tick(last_tick + 32'd3);
    write_sound(1'b1);
    send_tick(last_tick + 32'd1);
    send_tick(32'hFFFF_FFFF);
    send_tick(32'h0000_0000);
    send_request(OP_DEL, $urandom, 16'($urandom), 16'($urandom), 16'($urandom), 8'($urandom),
                 16'd2);

    for (int phase = 0; phase < PHASES; phase++) begin
      write_sound(phase[0]);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        roll = $urandom_range(0, 99);
        f_now = $urandom;
        f_delay = 16'($urandom);
        f_len = 16'($urandom);
        f_gap = 16'($urandom);
        f_cnt = 8'($urandom);
        f_target = 16'($urandom);
        if (roll < 45) begin
          f_op = OP_TICK;
          if ($urandom_range(0, 19) != 0) begin
            f_now = last_tick + 32'($urandom_range(0, 3));
          end
        end else if (roll < 75) begin
          f_op = OP_ADD;
          // mostly short patterns so windows open and close between ticks
          if ($urandom_range(0, 9) != 0) begin
            f_delay = 16'($urandom_range(0, 15));
            f_len = 16'($urandom_range(0, 8));
            f_gap = 16'($urandom_range(0, 8));
            f_cnt = 8'($urandom_range(0, 4));
          end
          adds_sent++;
        end else if (roll < 92) begin
          f_op = OP_DEL;
          // aim at handles handed out lately
          if ($urandom_range(0, 9) != 0) begin
            f_target = 16'(adds_sent - int'($urandom_range(0, 12)));
          end
        end else if (roll < 97) begin
          f_op = OP_NOP;
        end else begin
          f_op = 2'($urandom_range(0, 3));
        end
        if (f_op == OP_TICK) begin
          last_tick = f_now;
        end
        send_request(f_op, f_now, f_delay, f_len, f_gap, f_cnt, f_target);
      end
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4 * (SLOT_COUNT + 3)) @(negedge clk);

    $display("Ran %0d requests (%0d in the fill-and-retire rounds) over %0d sound-enable writes.",
             requests_sent, CLIMB_ROUNDS * (SLOT_COUNT + 1), sound_writes);
    $display("Checked %0d results, %0d mismatches.", checked, mismatches);
    if (mismatches == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
